// ===== rtl/mexp_pkg.sv =====
// Shared constants and types of the modular exponentiation unit.
package mexp_pkg;

   localparam int EXP_BITS = 63;
   localparam int MOD_BITS = 30;
   localparam int CNT_BITS = $clog2(MOD_BITS);

   localparam logic [MOD_BITS-1:0] MODULUS_RESET = MOD_BITS'(1000000007);

   typedef struct packed {
      logic                start;
      logic [MOD_BITS-1:0] x;
      logic [MOD_BITS-1:0] y;
   } mexp_mul_cmd_type;

   typedef struct packed {
      logic                done;
      logic [MOD_BITS-1:0] value;
   } mexp_mul_rsp_type;

endpackage

// ===== rtl/modular_exponentiation_unit.sv =====
// Top level of the modular exponentiation unit: sequencer, modulus register, result register.
//
// The unit computes req_base to the power req_exponent, modulo the modulus held in
// the configuration register, by right-to-left square and multiply.
// A word is accepted at a rising edge where start is high and busy is low. Unless the
// modulus is below two, busy then stays high until the result has been produced; one
// word is worked on at a time. The result word appears on rsp_power_mod, marked by
// rsp_strobe for exactly one cycle, and stays there until the next result. The
// receiver cannot stall, so nothing is ever held back. The modulus is written through
// csr_write_enable and csr_write_data; the user must write it only while the unit is
// idle, which the block itself does not enforce. Reset clears the sequencer and loads
// the modulus 1000000007. All work runs through one bit-serial modular multiplier that
// takes one multiplier bit per cycle. The base is first reduced by one pass of that
// multiplier, then each exponent bit up to the highest set bit costs one squaring plus
// one multiplication if set, with a decision state per bit; the squaring after the
// highest set bit is skipped. A modulus below two returns 0 on the cycle after acceptance.
module modular_exponentiation_unit import mexp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [MOD_BITS-1:0] req_base,
   input  logic [EXP_BITS-1:0] req_exponent,
   output logic                rsp_strobe,
   output logic [MOD_BITS-1:0] rsp_power_mod,
   input  logic                csr_write_enable,
   input  logic [MOD_BITS-1:0] csr_write_data
);

   // Sequencer states, one-hot.
   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_REDUCE  = 5'b00010,
      ST_DECIDE  = 5'b00100,
      ST_MUL_ACC = 5'b01000,
      ST_MUL_SQ  = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   logic [MOD_BITS-1:0] modulus_ff, modulus_in;
   logic [EXP_BITS-1:0] exp_ff, exp_in;
   logic [MOD_BITS-1:0] acc_ff, acc_in;
   logic [MOD_BITS-1:0] sq_ff, sq_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [MOD_BITS-1:0] rsp_power_mod_ff, rsp_power_mod_in;

   mexp_mul_cmd_type mul_cmd;
   mexp_mul_rsp_type mul_rsp;

   // The exponent register shifts right once per squaring, so bit 0 is always the
   // bit being worked on and the remaining bits above it tell whether work is left.
   logic exp_rest_zero;
   assign exp_rest_zero = (exp_ff[EXP_BITS-1:1] == '0);

   always_comb begin
      state_in         = state_ff;
      modulus_in       = modulus_ff;
      exp_in           = exp_ff;
      acc_in           = acc_ff;
      sq_in            = sq_ff;
      rsp_strobe_in    = 1'b0;
      rsp_power_mod_in = rsp_power_mod_ff;
      mul_cmd.start    = 1'b0;
      mul_cmd.x        = acc_ff;
      mul_cmd.y        = sq_ff;

      if (csr_write_enable) begin
         modulus_in = csr_write_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (modulus_ff < MOD_BITS'(2)) begin
                  // Every residue is zero for a modulus of zero or one.
                  rsp_strobe_in    = 1'b1;
                  rsp_power_mod_in = '0;
               end else begin
                  // Reduce the base as 1 times base, one base bit per cycle.
                  exp_in        = req_exponent;
                  acc_in        = MOD_BITS'(1);
                  mul_cmd.start = 1'b1;
                  mul_cmd.x     = MOD_BITS'(1);
                  mul_cmd.y     = req_base;
                  state_in      = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (mul_rsp.done) begin
               sq_in    = mul_rsp.value;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (exp_ff == '0) begin
               rsp_strobe_in    = 1'b1;
               rsp_power_mod_in = acc_ff;
               state_in         = ST_IDLE;
            end else if (exp_ff[0]) begin
               mul_cmd.start = 1'b1;
               mul_cmd.x     = acc_ff;
               mul_cmd.y     = sq_ff;
               state_in      = ST_MUL_ACC;
            end else begin
               mul_cmd.start = 1'b1;
               mul_cmd.x     = sq_ff;
               mul_cmd.y     = sq_ff;
               state_in      = ST_MUL_SQ;
            end
         end
         ST_MUL_ACC: begin
            if (mul_rsp.done) begin
               acc_in = mul_rsp.value;
               if (exp_rest_zero) begin
                  // No higher bit is set, so the running square is not needed.
                  rsp_strobe_in    = 1'b1;
                  rsp_power_mod_in = mul_rsp.value;
                  state_in         = ST_IDLE;
               end else begin
                  mul_cmd.start = 1'b1;
                  mul_cmd.x     = sq_ff;
                  mul_cmd.y     = sq_ff;
                  state_in      = ST_MUL_SQ;
               end
            end
         end
         ST_MUL_SQ: begin
            if (mul_rsp.done) begin
               sq_in    = mul_rsp.value;
               exp_in   = {1'b0, exp_ff[EXP_BITS-1:1]};
               state_in = ST_DECIDE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         modulus_ff    <= MODULUS_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         modulus_ff    <= modulus_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      exp_ff           <= exp_in;
      acc_ff           <= acc_in;
      sq_ff            <= sq_in;
      rsp_power_mod_ff <= rsp_power_mod_in;
   end

   mexp_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .modulus (modulus_ff),
      .cmd     (mul_cmd),
      .rsp     (mul_rsp)
   );

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_power_mod = rsp_power_mod_ff;

endmodule

// ===== rtl/mexp_mulmod.sv =====
// Bit-serial modular multiplier: one multiplier bit and one reduction per cycle.
module mexp_mulmod import mexp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [MOD_BITS-1:0] modulus,
   input  mexp_mul_cmd_type    cmd,
   output mexp_mul_rsp_type    rsp
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [MOD_BITS-1:0] r_ff, r_in;
   logic [MOD_BITS-1:0] x_ff, x_in;
   logic [MOD_BITS-1:0] y_ff, y_in;

   logic [MOD_BITS+1:0] sum;
   logic [MOD_BITS+2:0] diff1;
   logic [MOD_BITS+2:0] diff2;

   // r stays below the modulus, so 2r + x is below three times the modulus.
   always_comb begin
      sum   = {1'b0, r_ff, 1'b0} + (y_ff[MOD_BITS-1] ? {2'b00, x_ff} : '0);
      diff1 = {1'b0, sum} - {3'b000, modulus};
      diff2 = {1'b0, sum} - {2'b00, modulus, 1'b0};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      r_in    = r_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      if (busy_ff) begin
         if (!diff2[MOD_BITS+2]) begin
            r_in = diff2[MOD_BITS-1:0];
         end else if (!diff1[MOD_BITS+2]) begin
            r_in = diff1[MOD_BITS-1:0];
         end else begin
            r_in = sum[MOD_BITS-1:0];
         end
         y_in = {y_ff[MOD_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(MOD_BITS - 1);
         r_in    = '0;
         x_in    = cmd.x;
         y_in    = cmd.y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      r_ff   <= r_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.value = r_ff;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the modular exponentiation unit.
//
// Words are queued per modulus setting by the stimulus process, then offered one at a
// time by a clocked driver with random idle gaps. At each accepted word the driver
// computes the expected power by square and multiply under the modulus in force and
// files it. A clocked monitor takes every strobed result and compares it with the
// oldest filed expectation. The modulus is only rewritten once the unit has drained.
module testbench import mexp_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   // No word or result for this many cycles means the unit has hung. The limit lies well
   // above the slowest correct word, a full 63-bit exponent, together with the longest
   // idle gap of the driver, so it leaves a wide margin.
   localparam int unsigned QUIET_LIMIT = 20000;
   // Cycles allowed after the last result for any stray strobe to show itself.
   localparam int unsigned DRAIN_CYCLES = 64;
   localparam int unsigned WORDS_PER_SETTING = 14;

   typedef struct packed {
      logic [MOD_BITS-1:0] base;
      logic [EXP_BITS-1:0] exponent;
   } power_word_type;

   typedef struct packed {
      power_word_type      word;
      logic [MOD_BITS-1:0] modulus;
      logic [MOD_BITS-1:0] power;
   } power_check_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [MOD_BITS-1:0] req_base = '0;
   logic [EXP_BITS-1:0] req_exponent = '0;
   logic                rsp_strobe;
   logic [MOD_BITS-1:0] rsp_power_mod;
   logic                csr_write_enable = 1'b0;
   logic [MOD_BITS-1:0] csr_write_data = '0;

   // Words waiting to be offered, and the powers still owed by the unit.
   power_word_type  pending_words[$];
   power_check_type owed_powers[$];

   // Our own copy of the modulus register, tracking every write we make.
   logic [MOD_BITS-1:0] modulus_copy = MODULUS_RESET;

   int unsigned errors = 0;
   int unsigned results_checked = 0;
   int unsigned settings_used = 1;
   int unsigned idle_left = 0;
   int unsigned burst_left = 0;
   int unsigned quiet_cycles = 0;

   modular_exponentiation_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_base        (req_base),
      .req_exponent    (req_exponent),
      .rsp_strobe      (rsp_strobe),
      .rsp_power_mod   (rsp_power_mod),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Right-to-left square and multiply. Both factors are always below the modulus,
   // which is under 2^30, so every product fits comfortably in 64 bits.
   function automatic logic [MOD_BITS-1:0] expected_power(
      input logic [MOD_BITS-1:0] base,
      input logic [EXP_BITS-1:0] exponent,
      input logic [MOD_BITS-1:0] modulus
   );
      logic [63:0] acc;
      logic [63:0] square;
      logic [63:0] m;
      int          i;
      // A modulus of zero or one leaves nothing but the residue 0.
      if (modulus < 2) begin
         return '0;
      end
      m      = 64'(modulus);
      acc    = 64'd1;
      square = 64'(base) % m;
      for (i = 0; i < EXP_BITS; i++) begin
         if (exponent[i]) begin
            acc = (acc * square) % m;
         end
         square = (square * square) % m;
      end
      return acc[MOD_BITS-1:0];
   endfunction

   // Idle cycles before the next word is offered: mostly none or a few, now and then
   // a long pause, and occasional bursts in which the driver never idles at all.
   function automatic int unsigned next_gap();
      if (burst_left != 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 11) == 0) begin
         burst_left = $urandom_range(4, 12);
         return 0;
      end
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            return 0;
         end
         9: begin
            return $urandom_range(20, 200);
         end
         default: begin
            return $urandom_range(1, 5);
         end
      endcase
   endfunction

   task automatic report_mismatch(input string detail);
      $display("ERROR at %0t ns: %s", $time, detail);
      errors++;
   endtask

   // Driver. A word on offer is taken at an edge where busy is low; at that edge the
   // expectation is filed under the modulus in force, and the next word is either
   // offered straight away or held back for a random gap. start is assigned only once
   // per edge, so a word that follows without a gap keeps start high throughout.
   always @(posedge clock) begin
      power_word_type  word;
      power_check_type owed;
      if (reset) begin
         start      <= 1'b0;
         idle_left  = 0;
         burst_left = 0;
      end else if (!start || !busy) begin
         if (start) begin
            owed.word.base     = req_base;
            owed.word.exponent = req_exponent;
            owed.modulus       = modulus_copy;
            owed.power         = expected_power(req_base, req_exponent, modulus_copy);
            owed_powers.insert(owed_powers.size(), owed);
            idle_left = next_gap();
         end
         if (idle_left != 0) begin
            idle_left--;
            start <= 1'b0;
         end else if (pending_words.size() != 0) begin
            word = pending_words.pop_front();
            start        <= 1'b1;
            req_base     <= word.base;
            req_exponent <= word.exponent;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor and watchdog. Results cannot be held off, so every strobe is taken as it
   // comes and checked against the oldest owed power.
   always @(posedge clock) begin
      power_check_type owed;
      if (!reset) begin
         if (rsp_strobe) begin
            if (owed_powers.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with no word outstanding",
                                         rsp_power_mod));
            end else begin
               owed = owed_powers.pop_front();
               results_checked++;
               if (rsp_power_mod !== owed.power) begin
                  report_mismatch($sformatf(
                     "power_mod %0d, wanted %0d (base %0d, exponent 0x%0h, modulus %0d)",
                     rsp_power_mod, owed.power, owed.word.base, owed.word.exponent,
                     owed.modulus));
               end
            end
         end
         if ((start && !busy) || rsp_strobe) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
               $display("Watchdog: no word accepted and no result for %0d cycles",
                        QUIET_LIMIT);
               $display("modular_exponentiation_unit: mismatch");
               $finish;
            end
         end
      end
   end

   task automatic queue_word(input logic [MOD_BITS-1:0] base,
                             input logic [EXP_BITS-1:0] exponent);
      power_word_type word;
      word.base     = base;
      word.exponent = exponent;
      pending_words.insert(pending_words.size(), word);
   endtask

   // Random words. Most exponents are short, since every exponent bit below the highest
   // set one costs a squaring and each set bit a multiplication; one in six spans all
   // 63 bits so that each exponent bit is seen both set and clear. Bases are mostly
   // full-width random, with some placed just around the modulus and some tiny ones.
   task automatic queue_random_words(input int unsigned count);
      logic [MOD_BITS-1:0] base;
      logic [EXP_BITS-1:0] exponent;
      int unsigned         width;
      repeat (count) begin
         case ($urandom_range(0, 19))
            0, 1, 2: begin
               base = modulus_copy + MOD_BITS'($urandom_range(0, 2)) - MOD_BITS'(1);
            end
            3, 4: begin
               base = MOD_BITS'($urandom_range(0, 3));
            end
            default: begin
               base = MOD_BITS'($urandom);
            end
         endcase
         exponent = EXP_BITS'({$urandom, $urandom});
         if ($urandom_range(0, 5) != 0) begin
            width    = $urandom_range(1, 16);
            exponent = exponent & ((EXP_BITS'(1) << width) - EXP_BITS'(1));
         end
         queue_word(base, exponent);
      end
   endtask

   // Returns on a falling edge once every word has been taken, every result has come
   // back and the unit has dropped busy, so that nothing races the clocked processes.
   task automatic wait_until_drained();
      do begin
         @(negedge clock);
      end while (pending_words.size() != 0 || start || owed_powers.size() != 0 || busy);
   endtask

   task automatic write_modulus(input logic [MOD_BITS-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      modulus_copy = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      settings_used++;
      @(negedge clock);
   endtask

   initial begin
      logic [MOD_BITS-1:0] moduli[8];
      int                  k;

      // Moduli after the reset value: the largest, the smallest proper one, the two
      // degenerate ones, a small odd one, a power of two and two random picks.
      moduli[0] = {MOD_BITS{1'b1}};
      moduli[1] = MOD_BITS'(2);
      moduli[2] = MOD_BITS'(0);
      moduli[3] = MOD_BITS'(1);
      moduli[4] = MOD_BITS'(3);
      moduli[5] = MOD_BITS'(1) << (MOD_BITS - 1);
      moduli[6] = MOD_BITS'($urandom_range(2, 1000));
      moduli[7] = MOD_BITS'($urandom);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed words under the modulus left by reset.
      queue_word('0, '0);                                   // zero to the power zero
      queue_word('0, EXP_BITS'(5));                         // zero base
      queue_word(MOD_BITS'(1), {EXP_BITS{1'b1}});           // one to the largest power
      queue_word({MOD_BITS{1'b1}}, {EXP_BITS{1'b1}});       // both fields at their maximum
      queue_word({MOD_BITS{1'b1}}, '0);                     // widest base, zero exponent
      queue_word({MOD_BITS{1'b1}}, EXP_BITS'(1));           // widest base reduced once
      queue_word(MOD_BITS'(2), EXP_BITS'(1) << (EXP_BITS - 1)); // top exponent bit alone
      queue_word(MODULUS_RESET, EXP_BITS'(3));              // base equal to the modulus
      queue_word(MODULUS_RESET - MOD_BITS'(1), EXP_BITS'(2)); // base just below it
      queue_word(MODULUS_RESET + MOD_BITS'(1), EXP_BITS'(7)); // base just above it
      queue_word(MOD_BITS'(3), EXP_BITS'(MODULUS_RESET - MOD_BITS'(2))); // inverse of 3
      queue_word(MOD_BITS'(12345), EXP_BITS'({32{2'b01}})); // alternating exponent bits
      queue_word(MOD_BITS'(7), EXP_BITS'({32{2'b10}}));
      queue_random_words(WORDS_PER_SETTING);
      wait_until_drained();

      // Each further setting opens with a zero exponent on the widest base, which
      // shows the degenerate moduli returning 0 where any other gives 1.
      for (k = 0; k < 8; k++) begin
         write_modulus(moduli[k]);
         queue_word({MOD_BITS{1'b1}}, '0);
         queue_random_words(WORDS_PER_SETTING);
         wait_until_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (owed_powers.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", owed_powers.size()));
      end

      $display("Checked %0d results under %0d modulus settings, from 0 and 1 up to 2^30-1,",
               results_checked, settings_used);
      $display("with bases around each modulus and exponents from zero to 63 bits wide.");
      if (errors == 0) begin
         $display("modular_exponentiation_unit: match");
      end else begin
         $display("modular_exponentiation_unit: mismatch");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/mexp_pkg.sv
rtl/mexp_mulmod.sv
rtl/modular_exponentiation_unit.sv
tb/testbench.sv
